// ----- rtl/core/rgbpq_pkg.sv -----
package rgbpq_pkg;

  localparam int PaletteEntries = 256;
  localparam int IdxW = $clog2(PaletteEntries);

  localparam logic [2:0] MODE_STD     = 3'd0;
  localparam logic [2:0] MODE_STD_LIM = 3'd1;
  localparam logic [2:0] MODE_PRIMARY = 3'd2;
  localparam logic [2:0] MODE_GRAY    = 3'd3;
  localparam logic [2:0] MODE_SGRAY   = 3'd4;
  localparam logic [2:0] MODE_BW      = 3'd5;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [0:0] REG_MODE = 1'b0;
  localparam logic [0:0] REG_BANK = 1'b1;

  localparam logic [14:0] GREY15 = 15'h3DEF;

  function automatic logic [14:0] grey(input logic [4:0] v);
    grey = {v, v, v};
  endfunction

  function automatic logic [14:0] primary_preset(input logic [3:0] i);
    case (i)
      4'd0:  primary_preset = 15'h0000;
      4'd1:  primary_preset = 15'h18C6;
      4'd2:  primary_preset = 15'h77BD;
      4'd3:  primary_preset = 15'h2D6B;
      4'd4:  primary_preset = 15'h18DD;
      4'd5:  primary_preset = 15'h1BA6;
      4'd6:  primary_preset = 15'h74C6;
      4'd7:  primary_preset = 15'h1BBD;
      4'd8:  primary_preset = 15'h74DD;
      4'd9:  primary_preset = 15'h77A6;
      4'd10: primary_preset = 15'h197D;
      4'd11: primary_preset = 15'h1BAB;
      4'd12: primary_preset = 15'h7566;
      4'd13: primary_preset = 15'h2CDD;
      4'd14: primary_preset = 15'h2FA6;
      default: primary_preset = 15'h74CB;
    endcase
  endfunction

  function automatic logic [4:0] round_channel(input logic [4:0] c);
    logic [5:0] t;
    t = {1'b0, c};
    if (c[1:0] != 2'b00) t = {1'b0, c & 5'h1C} + 6'd4;
    if (t < 6'd6) t = 6'd6;
    if (t > 6'd30) t = 6'd30;
    round_channel = t[4:0];
  endfunction

  function automatic logic [3:0] primary_code(input logic [4:0] r, input logic [4:0] g,
                                              input logic [4:0] b);
    logic [3:0] c;
    c = 4'd3;
    if (r < 5'd12 && g < 5'd11 && b < 5'd11) c = 4'd1;
    else if (r > 5'd19 && g > 5'd19 && b > 5'd19) c = 4'd2;
    else if (r > 5'd19 && g > 5'd19) c = (b > 5'd14) ? 4'd2 : 4'd7;
    else if (r > 5'd19 && b > 5'd19) c = (g > 5'd14) ? 4'd2 : 4'd8;
    else if (g > 5'd19 && b > 5'd19) c = (r > 5'd14) ? 4'd2 : 4'd9;
    else if (r > 5'd19) begin
      if (g > 5'd11) c = (b > 5'd11) ? ((g < b) ? 4'd8 : 4'd7) : 4'd10;
      else c = (b > 5'd11) ? 4'd13 : 4'd4;
    end else if (g > 5'd19) begin
      if (r > 5'd11) c = (b > 5'd11) ? ((r < b) ? 4'd9 : 4'd7) : 4'd11;
      else c = (b > 5'd11) ? 4'd14 : 4'd5;
    end else if (b > 5'd19) begin
      if (r > 5'd11 && g > 5'd11) c = (r < g) ? 4'd9 : 4'd8;
      else if (r <= 5'd11 && g > 5'd11) c = 4'd12;
      else c = 4'd15;
    end
    primary_code = c;
  endfunction

  // Sum of three channels is at most 93, so a 7-bit value divided by 3 by reciprocal.
  function automatic logic [4:0] div3(input logic [6:0] s);
    logic [13:0] p;
    p = {7'd0, s} * 14'd43;
    div3 = p[11:7];
  endfunction

endpackage

// ----- rtl/core/rgb555_palette_quantizer_top.sv -----
// RGB555 palette quantizer.
// Input words (in_tdata = {pixel_color, operation}) start a begin-image
// operation or quantize one pixel. In modes 0 to 5 each word yields one or more
// result words on the out_ channel; tlast marks the final result of an input word.
// A begin in a standard mode clears entries 0..max-1 one per cycle and then
// reports the grey entry at max. A preset begin emits 3, 16 or 33 entry
// words, one per cycle when the receiver keeps up.
// A standard pixel scans the palette through a registered memory read port,
// each entry examined in a read state and then a compare state; the other
// modes register their result directly from the input word. The scan loop
// over the palette memory sets the rate.
// The block accepts no new word until all results of the current word are
// taken. Results sit in an output register; a stalled receiver holds it and
// the sequencer waits. Modes 6 and 7 produce no result.
// Reset clears the palette state by treating all entries as invalid through
// a valid bit per entry; mode and bank return to zero.
// Configuration: register 0 mode at address 0, register 1 bank at address 4.
module rgb555_palette_quantizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[0], pixel_color[16:1], zero fill
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [39:0] out_tdata,  // pixel_valid[0], pixel_code[9:1], entry_written[10],
                                  // entry_index[18:11], entry_color[33:19], zero fill
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rgbpq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int MaxStd = (PaletteEntries - 1 < 'hFF) ? PaletteEntries - 1 : 'hFF;
  localparam int MaxLim = (PaletteEntries - 1 < 'hDF) ? PaletteEntries - 1 : 'hDF;

  logic [2:0] state_r, state_nxt;
  logic [2:0] mode_r;
  logic [3:0] bank_r;
  logic       cfg_wr;
  logic [14:0] mem [PaletteEntries];
  logic [PaletteEntries-1:0] vld_r;
  logic [14:0] rd_data_r;
  logic        rd_vld_r;
  logic [IdxW:0] idx_r;
  logic [14:0] color_r;
  logic [IdxW:0] max_r;
  logic [5:0]  pcnt_r;
  logic        ov_r, olast_r, opv_r, owr_r;
  logic [8:0]  ocode_r;
  logic [7:0]  oidx_r;
  logic [14:0] ocol_r;
  logic        mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [14:0] mem_wd;
  logic [4:0]  r_c, g_c, b_c, avg;
  logic [8:0]  base;
  logic [5:0]  pre_n;
  logic [14:0] pre_val;
  logic [14:0] entry;
  logic        op_in;
  logic [15:0] px_in;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_BANK) ? {28'd0, bank_r} : {29'd0, mode_r};
  assign op_in = in_tdata[0];
  assign px_in = in_tdata[16:1];
  assign r_c = px_in[4:0];
  assign g_c = px_in[9:5];
  assign b_c = px_in[14:10];
  assign base = {1'b0, bank_r, 4'd0};
  assign avg = div3({2'd0, r_c} + {2'd0, g_c} + {2'd0, b_c});
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tlast = olast_r;
  assign out_tdata = {6'd0, ocol_r, oidx_r, owr_r, ocode_r, opv_r};
  assign entry = rd_vld_r ? rd_data_r : 15'd0;

  always_comb begin
    pre_n = 6'd3;
    pre_val = 15'd0;
    case (mode_r)
      MODE_PRIMARY: begin
        pre_n = 6'd16;
        pre_val = primary_preset(pcnt_r[3:0]);
      end
      MODE_GRAY: begin
        pre_n = 6'd33;
        pre_val = (pcnt_r == 6'd0) ? 15'd0 : grey(5'(pcnt_r - 6'd1));
      end
      MODE_SGRAY: begin
        pre_n = 6'd16;
        pre_val = (pcnt_r < 6'd2) ? 15'd0 : grey({pcnt_r[3:0], 1'b0});
      end
      default: pre_val = (pcnt_r == 6'd2) ? 15'h7FFF : 15'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[idx_r[IdxW-1:0]];
    rd_vld_r <= vld_r[idx_r[IdxW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    mem_we = 1'b0;
    mem_wa = idx_r[IdxW-1:0];
    mem_wd = 15'd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready && mode_r <= MODE_BW) begin
          if (op_in == OP_BEGIN)
            state_nxt = (mode_r <= MODE_STD_LIM) ? S_CLEAR : S_PRE;
          else if (!px_in[15] && mode_r <= MODE_STD_LIM) state_nxt = S_READ;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = (idx_r == max_r) ? GREY15 : 15'd0;
        if (idx_r == max_r) state_nxt = S_IDLE;
      end
      S_PRE: begin
        if (!ov_r || out_tready) begin
          mem_we = 1'b1;
          mem_wa = IdxW'(pcnt_r);
          mem_wd = pre_val;
          if (pcnt_r + 6'd1 == pre_n) state_nxt = S_IDLE;
        end
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (idx_r >= max_r) state_nxt = S_OUT;
        else if (entry == 15'd0) begin
          mem_we = 1'b1;
          mem_wd = color_r;
          state_nxt = S_OUT;
        end else if (entry == color_r) state_nxt = S_OUT;
        else state_nxt = S_READ;
      end
      S_OUT: if (!ov_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= MODE_STD;
      bank_r <= 4'd0;
      vld_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_MODE) mode_r <= cfg_pwdata[2:0];
      if (cfg_wr && cfg_paddr[2] == REG_BANK) bank_r <= cfg_pwdata[3:0];
      if (mem_we) vld_r[mem_wa] <= 1'b1;
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          max_r <= (mode_r == MODE_STD_LIM) ? (IdxW+1)'(MaxLim) : (IdxW+1)'(MaxStd);
          // The palette search starts at entry 1; the clear pass starts at 0.
          idx_r <= (op_in == OP_PIXEL) ? (IdxW+1)'(1) : '0;
          pcnt_r <= 6'd0;
          color_r <= {round_channel(b_c), round_channel(g_c), round_channel(r_c)};
          if (in_tvalid && in_tready && mode_r <= MODE_BW && op_in == OP_PIXEL
              && (px_in[15] || mode_r > MODE_STD_LIM)) begin
            ov_r <= 1'b1;
            opv_r <= 1'b1;
            owr_r <= 1'b0;
            oidx_r <= 8'd0;
            ocol_r <= 15'd0;
            olast_r <= 1'b1;
            if (px_in[15]) ocode_r <= base;
            else case (mode_r)
              MODE_PRIMARY: ocode_r <= base + {5'd0, primary_code(r_c, g_c, b_c)};
              MODE_GRAY: ocode_r <= base + {4'd0, avg} + 9'd1;
              MODE_SGRAY: ocode_r <= base + ((avg[4:1] == 4'd0) ? 9'd1 : {5'd0, avg[4:1]});
              default: ocode_r <= base + ((r_c < 5'd17 && g_c < 5'd17 && b_c < 5'd17)
                                          ? 9'd1 : 9'd2);
            endcase
          end
        end
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == max_r) begin
            ov_r <= 1'b1;
            opv_r <= 1'b0;
            ocode_r <= 9'd0;
            owr_r <= 1'b1;
            oidx_r <= 8'(max_r);
            ocol_r <= GREY15;
            olast_r <= 1'b1;
          end
        end
        S_PRE: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            opv_r <= 1'b0;
            ocode_r <= 9'd0;
            owr_r <= 1'b1;
            oidx_r <= {2'd0, pcnt_r};
            ocol_r <= pre_val;
            olast_r <= (pcnt_r + 6'd1 == pre_n);
            pcnt_r <= pcnt_r + 6'd1;
          end
        end
        S_READ: ;
        S_CMP: begin
          opv_r <= 1'b1;
          olast_r <= 1'b1;
          owr_r <= 1'b0;
          oidx_r <= 8'd0;
          ocol_r <= 15'd0;
          if (idx_r >= max_r) ocode_r <= 9'(max_r);
          else begin
            ocode_r <= base + 9'(idx_r);
            if (entry == 15'd0) begin
              owr_r <= 1'b1;
              oidx_r <= 8'(idx_r);
              ocol_r <= color_r;
            end else if (entry != color_r) idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: if (!ov_r) ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/rgbpq_checker.sv -----
module rgbpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tlast))
    else $error("last flag changed while stalled");
  a_no_accept_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_code_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[9:1] == 9'd0)
    else $error("code set without pixel valid");
endmodule

bind rgb555_palette_quantizer_top rgbpq_checker u_chk (.*);
